FILE: src/sma_pkg.sv
// shared types and constants for the spi master register access block
// no dependencies; imported by every module of the block
`default_nettype none

package sma_pkg;

    localparam int BITS_PER_WORD = 8;
    localparam int LAST_BIT      = BITS_PER_WORD - 1;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_WORD);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QCOUNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_WRITE     = 2'd0,
        KIND_READ_ADDR = 2'd1,
        KIND_READ_DATA = 2'd2
    } kind_t;

    typedef struct packed {
        logic       mode;
        logic       phase;
        logic [7:0] tx_byte;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] sampled_bits;
    } cmd_t;

    typedef struct packed {
        logic       cs_n;
        logic       sck;
        logic       mosi;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       last_of_run;
    } pin_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] tx_byte;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] sampled_bits;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

endpackage

`default_nettype wire

FILE: src/sma_front.sv
// front end: takes a request and classifies it into a transfer job
// depends on sma_pkg
`default_nettype none

module sma_front (
    input  wire sma_pkg::cmd_t cmd,
    output sma_pkg::job_t      job
);
    import sma_pkg::*;

    kind_t kind;

    always_comb
    begin
        if (!cmd.mode)
        begin
            kind = KIND_WRITE;
        end
        else if (!cmd.phase)
        begin
            kind = KIND_READ_ADDR;
        end
        else
        begin
            kind = KIND_READ_DATA;
        end
    end

    assign job.kind         = kind;
    assign job.tx_byte      = cmd.tx_byte;
    assign job.first_byte   = cmd.first_byte;
    assign job.last_byte    = cmd.last_byte;
    assign job.sampled_bits = cmd.sampled_bits;

endmodule

`default_nettype wire

FILE: src/sma_queue.sv
// two-entry job queue between front end and pin sequencer
// depends on sma_pkg
`default_nettype none

module sma_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire sma_pkg::job_t job,
    output logic               full,
    input  wire                pop,
    output sma_pkg::head_t     head
);
    import sma_pkg::*;

    job_t                slot0_reg;
    job_t                slot1_reg;
    logic [QCOUNT_W-1:0] count_reg;
    logic [QCOUNT_W-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCOUNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCOUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            if (do_push && (count_reg == QCOUNT_W'(1)))
            begin
                slot0_reg <= job;
            end
            else
            begin
                slot0_reg <= slot1_reg;
            end
            if (do_push && (count_reg == QCOUNT_W'(2)))
            begin
                slot1_reg <= job;
            end
        end
        else if (do_push)
        begin
            if (count_reg == '0)
            begin
                slot0_reg <= job;
            end
            else
            begin
                slot1_reg <= job;
            end
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.job   = slot0_reg;

endmodule

`default_nettype wire

FILE: src/sma_back.sv
// pin sequencer: turns one job into its run of chip select, clock and data-out updates
// depends on sma_pkg
`default_nettype none

module sma_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire sma_pkg::head_t head,
    output logic                pop,
    output logic                pin_valid,
    input  wire                 pin_stall,
    output sma_pkg::pin_t       pin
);
    import sma_pkg::*;

    typedef enum logic [2:0] {
        ST_CLK_IDLE,
        ST_CS_LOW,
        ST_BIT_A,
        ST_BIT_B,
        ST_BIT_C,
        ST_CS_HIGH,
        ST_CLK_HIGH
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    state_t               st;
    logic                 busy_reg;
    logic [BIT_IDX_W-1:0] bit_reg;
    logic [BIT_IDX_W-1:0] bit_next;
    logic [BIT_IDX_W-1:0] bitn;
    logic                 cs_reg;
    logic                 cs_next;
    logic                 sck_reg;
    logic                 sck_next;
    logic                 mosi_reg;
    logic                 mosi_next;
    logic                 pin_valid_reg;
    pin_t                 pin_reg;
    pin_t                 pin_next;
    job_t                 cur_reg;
    job_t                 src;
    logic                 go;
    logic                 done;
    logic                 wr;
    logic                 rd;

    assign src  = busy_reg ? cur_reg : head.job;
    assign wr   = (src.kind == KIND_WRITE);
    assign rd   = (src.kind == KIND_READ_DATA);
    assign bitn = busy_reg ? bit_reg : '0;
    assign go   = (!pin_valid_reg || !pin_stall) && (busy_reg || head.valid);
    assign pop  = go && !busy_reg;

    always_comb
    begin
        if (busy_reg)
        begin
            st = state_reg;
        end
        else if (head.job.first_byte)
        begin
            st = ST_CLK_IDLE;
        end
        else if (head.job.kind == KIND_READ_DATA)
        begin
            st = ST_BIT_B;
        end
        else
        begin
            st = ST_BIT_A;
        end
    end

    always_comb
    begin
        cs_next    = cs_reg;
        sck_next   = sck_reg;
        mosi_next  = mosi_reg;
        bit_next   = bitn;
        state_next = st;
        done       = 1'b0;
        unique case (st)
            ST_CLK_IDLE:
            begin
                sck_next   = !wr;
                state_next = ST_CS_LOW;
            end
            ST_CS_LOW:
            begin
                cs_next    = 1'b0;
                state_next = rd ? ST_BIT_B : ST_BIT_A;
            end
            ST_BIT_A:
            begin
                mosi_next  = src.tx_byte[BIT_IDX_W'(LAST_BIT) - bitn];
                state_next = ST_BIT_B;
            end
            ST_BIT_B:
            begin
                sck_next   = wr;
                state_next = ST_BIT_C;
            end
            ST_BIT_C:
            begin
                sck_next = !wr;
                if (bitn == BIT_IDX_W'(LAST_BIT))
                begin
                    if (src.last_byte)
                    begin
                        state_next = ST_CS_HIGH;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                else
                begin
                    bit_next   = bitn + BIT_IDX_W'(1);
                    state_next = rd ? ST_BIT_B : ST_BIT_A;
                end
            end
            ST_CS_HIGH:
            begin
                cs_next = 1'b1;
                if (wr)
                begin
                    state_next = ST_CLK_HIGH;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            ST_CLK_HIGH:
            begin
                sck_next = 1'b1;
                done     = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        pin_next.cs_n        = cs_next;
        pin_next.sck         = sck_next;
        pin_next.mosi        = mosi_next;
        pin_next.rx_valid    = done && rd;
        pin_next.rx_byte     = (done && rd) ? src.sampled_bits : '0;
        pin_next.last_of_run = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLK_IDLE;
            busy_reg      <= 1'b0;
            bit_reg       <= '0;
            cs_reg        <= 1'b1;
            sck_reg       <= 1'b1;
            mosi_reg      <= 1'b0;
            pin_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            state_reg     <= state_next;
            busy_reg      <= !done;
            bit_reg       <= bit_next;
            cs_reg        <= cs_next;
            sck_reg       <= sck_next;
            mosi_reg      <= mosi_next;
            pin_valid_reg <= 1'b1;
        end
        else if (!pin_stall)
        begin
            pin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            pin_reg <= pin_next;
        end
        if (pop)
        begin
            cur_reg <= head.job;
        end
    end

    assign pin_valid = pin_valid_reg;
    assign pin       = pin_reg;

endmodule

`default_nettype wire

FILE: src/spi_master_register_access.sv
// top level of the spi master register access block
// depends on sma_pkg, sma_front, sma_queue, sma_back
//
// usage:
//   request channel (cmd_valid, cmd_stall, cmd): one byte of an spi transfer with its
//   mode, phase, first and last flags and the eight data-in samples for a read data byte
//   pin channel (pin_valid, pin_stall, pin): one item per pin update step, carrying
//   the chip select, clock and data-out levels after that step; the last item of a
//   request has last_of_run set, and for a read data byte also rx_valid and rx_byte
//   a request makes 16 to 28 pin items, one per cycle while pin_stall is low, set
//   by the one-update-per-cycle pin sequencer
//   the first pin item leaves the pin register after the request has passed the queue;
//   runs of consecutive requests follow each other with no idle cycle
//   a two-entry queue holds requests ahead of the sequencer; cmd_stall rises only
//   when it is full
//   while pin_stall is high a pending pin item is held and the sequencer waits
//   reset: chip select high, clock high, data-out low, queue empty, no pin item
`default_nettype none

module spi_master_register_access (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cmd_valid,
    output logic               cmd_stall,
    input  wire sma_pkg::cmd_t cmd,
    output logic               pin_valid,
    input  wire                pin_stall,
    output sma_pkg::pin_t      pin
);
    import sma_pkg::*;

    job_t  job;
    head_t head;
    logic  full;
    logic  pop;

    sma_front u_front (
        .cmd (cmd),
        .job (job)
    );

    sma_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_valid),
        .job   (job),
        .full  (full),
        .pop   (pop),
        .head  (head)
    );

    sma_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .pin_valid (pin_valid),
        .pin_stall (pin_stall),
        .pin       (pin)
    );

    assign cmd_stall = full;

endmodule

`default_nettype wire

FILE: src/sma_checker.sv
// port-level checks for the spi master register access block, bound to the top level
// depends on sma_pkg
`default_nettype none

module sma_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                cmd_valid,
    input wire                cmd_stall,
    input wire                pin_valid,
    input wire                pin_stall,
    input wire sma_pkg::pin_t pin
);
    import sma_pkg::*;

    // held pin item stays put
    a_pin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pin_valid && pin_stall |=> pin_valid && $stable(pin))
        else $error("pin item changed while stalled");

    // read byte only comes with the final update of a request
    a_rx_last: assert property (@(posedge clk) disable iff (!rst_n)
        pin_valid && pin.rx_valid |-> pin.last_of_run)
        else $error("rx_valid without last_of_run");

    a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pin_valid && !pin.rx_valid |-> pin.rx_byte == 8'd0)
        else $error("rx_byte nonzero without rx_valid");

    // no pin item while reset is asserted
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !pin_valid)
        else $error("pin item during reset");

    // queue only fills up on an offered request
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_stall) |-> $past(cmd_valid))
        else $error("cmd_stall rose without a request");

endmodule

bind spi_master_register_access sma_checker u_sma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .pin_valid (pin_valid),
    .pin_stall (pin_stall),
    .pin       (pin)
);

`default_nettype wire
